### src/bgc_pkg.sv
// Shared types and codes for the button gesture classifier.
`default_nettype none

package bgc_pkg;

  localparam int unsigned StampW = 16;
  localparam int unsigned TallyW = 2;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_ROTATE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_WINDOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_TIME     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROTATE_TIME   = 2'd2;

  localparam logic [StampW-1:0] DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [StampW-1:0] LONG_TIME_RST     = 16'd1000;
  localparam logic [StampW-1:0] ROTATE_TIME_RST   = 16'd500;

  localparam logic [TallyW-1:0] TALLY_ZERO = 2'd0;
  localparam logic [TallyW-1:0] TALLY_ONE  = 2'd1;
  localparam logic [TallyW-1:0] TALLY_TWO  = 2'd2;
  localparam logic [TallyW-1:0] TALLY_MAX  = 2'd3;

endpackage

`default_nettype wire

### src/button_gesture_classifier.sv
// Top level of the button gesture classifier: input stage, gesture logic, result register.
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    command[1:0], now_ms[15:0]
// out       source     out_valid / out_stall  gesture[1:0]
// cfg       sink       cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[15:0]
//
// One item per cycle sustained while the output is not stalled; the input is
// registered, then the gesture logic feeds the result register.
// Synchronous reset clears press state, valids and restores register defaults.
// A stalled result holds the input stage; the input stage still takes one
// item while a result waits. cfg_ready is always high.

module button_gesture_classifier import bgc_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [1:0]          command,
  input  wire  [StampW-1:0]   now_ms,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          gesture,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [CfgIdxW-1:0]  cfg_index,
  input  wire  [StampW-1:0]   cfg_data
);

  logic [StampW-1:0] double_window;
  logic [StampW-1:0] long_time;
  logic [StampW-1:0] rotate_time;

  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [StampW-1:0] s1_now;

  logic [StampW-1:0] last_press_stamp;
  logic [TallyW-1:0] press_tally;
  logic              held;

  logic [StampW-1:0] last_press_stamp_next;
  logic [TallyW-1:0] press_tally_next;
  logic              held_next;
  gesture_t          gesture_next;
  logic [StampW-1:0] dt;
  logic [TallyW-1:0] tally_inc;
  logic              s1_adv;
  logic              in_xfer;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && !(out_valid && out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_window <= DOUBLE_WINDOW_RST;
      long_time     <= LONG_TIME_RST;
      rotate_time   <= ROTATE_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DOUBLE_WINDOW: double_window <= cfg_data;
        CFG_LONG_TIME:     long_time     <= cfg_data;
        CFG_ROTATE_TIME:   rotate_time   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd <= cmd_t'(command);
      s1_now <= now_ms;
    end
  end

  assign dt        = s1_now - last_press_stamp;
  assign tally_inc = (press_tally == TALLY_MAX) ? TALLY_MAX : press_tally + TALLY_ONE;

  always_comb begin
    last_press_stamp_next = last_press_stamp;
    press_tally_next      = press_tally;
    held_next             = held;
    gesture_next          = GEST_NONE;
    unique case (s1_cmd)
      CMD_PRESS: begin
        if (!held) begin
          held_next             = 1'b1;
          press_tally_next      = tally_inc;
          last_press_stamp_next = s1_now;
          if (tally_inc == TALLY_TWO && dt <= double_window) begin
            gesture_next     = GEST_DOUBLE;
            press_tally_next = TALLY_ZERO;
          end
        end
      end
      CMD_RELEASE: begin
        if (held) begin
          held_next = 1'b0;
          if (press_tally == TALLY_ONE) begin
            priority if (dt > long_time) begin
              gesture_next     = GEST_LONG;
              press_tally_next = TALLY_ZERO;
            end else if (dt > double_window) begin
              gesture_next     = GEST_SINGLE;
              press_tally_next = TALLY_ZERO;
            end else begin
              // hold the press pending
              press_tally_next = press_tally;
            end
          end
        end
      end
      CMD_TICK: begin
        if (press_tally == TALLY_ONE) begin
          priority if (held && dt > long_time) begin
            gesture_next     = GEST_LONG;
            press_tally_next = TALLY_ZERO;
          end else if (!held && dt > double_window) begin
            gesture_next     = GEST_SINGLE;
            press_tally_next = TALLY_ZERO;
          end else begin
            // hold the press pending
            press_tally_next = press_tally;
          end
        end
      end
      CMD_ROTATE: begin
        if (press_tally == TALLY_ONE && dt > rotate_time) begin
          gesture_next = GEST_SINGLE;
        end
        press_tally_next = TALLY_ZERO;
      end
      default: ;
    endcase
  end

  // commit state only when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_press_stamp <= '0;
      press_tally      <= TALLY_ZERO;
      held             <= 1'b0;
    end else if (s1_adv) begin
      last_press_stamp <= last_press_stamp_next;
      press_tally      <= press_tally_next;
      held             <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      gesture <= gesture_next;
    end
  end

  a_rotate_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_cmd == CMD_ROTATE |=> press_tally == TALLY_ZERO)
    else $error("rotation switch left a pending press");

  a_gesture_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && gesture_next != GEST_NONE |=> press_tally == TALLY_ZERO)
    else $error("reported gesture did not clear the tally");

  a_press_holds: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_cmd == CMD_PRESS |=> held)
    else $error("press did not set held");

  a_long_single_press: assert property (@(posedge clk) disable iff (rst)
    s1_adv && gesture_next == GEST_LONG |-> press_tally == TALLY_ONE)
    else $error("long press reported without exactly one pending press");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_now) && $stable(s1_cmd))
    else $error("input stage changed while stalled");

endmodule

`default_nettype wire

### test/tb_top.sv
// Testbench for button_gesture_classifier: directed and random gesture sequences checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
  import bgc_pkg::*;

  localparam int HoldCycles = 400;
  localparam int StallLimit = 3000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          command = 2'd0;
  logic [StampW-1:0]   now_ms = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          gesture;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [StampW-1:0]   cfg_data = '0;

  // predictor copy of timing registers and press state
  logic [StampW-1:0] dbl_window = DOUBLE_WINDOW_RST;
  logic [StampW-1:0] long_time = LONG_TIME_RST;
  logic [StampW-1:0] rot_time = ROTATE_TIME_RST;
  logic [StampW-1:0] press_stamp = '0;
  logic [TallyW-1:0] tally = TALLY_ZERO;
  logic              held_now = 1'b0;

  gesture_t          gesture_q[$];
  logic [StampW-1:0] clock_ms = '0;
  int                items_sent = 0;
  int                burst_left = 0;
  bit                valid_up = 1'b0;
  int                err_cnt = 0;
  int                idle_cycles = 0;
  int                pattern_left = 0;
  int                stall_pct = 0;
  logic              hold_on = 1'b0;
  event              hold_start;

  button_gesture_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gesture   (gesture),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 20) $display("%0t: %s", $time, msg);
  endtask

  function automatic gesture_t classify_event(cmd_t c, logic [StampW-1:0] t);
    logic [StampW-1:0] dt;
    gesture_t g;
    dt = t - press_stamp;
    g = GEST_NONE;
    case (c)
      CMD_PRESS: if (!held_now) begin
        held_now = 1'b1;
        if (tally != TALLY_MAX) tally = tally + 1'b1;
        if (tally == TALLY_TWO && dt <= dbl_window) begin
          g = GEST_DOUBLE;
          tally = TALLY_ZERO;
        end
        press_stamp = t;
      end
      CMD_RELEASE: if (held_now) begin
        held_now = 1'b0;
        if (tally == TALLY_ONE) begin
          if (dt > long_time) begin
            g = GEST_LONG;
            tally = TALLY_ZERO;
          end else if (dt > dbl_window) begin
            g = GEST_SINGLE;
            tally = TALLY_ZERO;
          end
        end
      end
      CMD_TICK: if (tally == TALLY_ONE) begin
        if (held_now && dt > long_time) begin
          g = GEST_LONG;
          tally = TALLY_ZERO;
        end else if (!held_now && dt > dbl_window) begin
          g = GEST_SINGLE;
          tally = TALLY_ZERO;
        end
      end
      default: begin
        if (tally == TALLY_ONE && dt > rot_time) g = GEST_SINGLE;
        tally = TALLY_ZERO;
      end
    endcase
    return g;
  endfunction

  // offset that lands on, beside or well away from a threshold
  function automatic logic [StampW-1:0] near_threshold(logic [StampW-1:0] thr);
    case ($urandom_range(0, 6))
      0: return thr - 16'd1;
      1: return thr;
      2: return thr + 16'd1;
      3: return 16'($urandom_range(0, thr));
      4: return thr + 16'($urandom_range(1, 200));
      5: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_item(cmd_t c, logic [StampW-1:0] t);
    int gap;
    in_valid <= 1'b1;
    command <= c;
    now_ms <= t;
    valid_up = 1'b1;
    do @(posedge clk); while (in_stall);
    gesture_q.push_back(classify_event(c, t));
    clock_ms = t;
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 60);
    end
  endtask

  // drop valid and wait until every predicted gesture has been checked
  task automatic drain_results();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk); while (gesture_q.size() != 0);
  endtask

  task automatic write_timing_reg(logic [CfgIdxW-1:0] idx, logic [StampW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DOUBLE_WINDOW: dbl_window = d;
      CFG_LONG_TIME:     long_time = d;
      CFG_ROTATE_TIME:   rot_time = d;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [StampW-1:0] w, logic [StampW-1:0] l,
                            logic [StampW-1:0] r);
    drain_results();
    write_timing_reg(CFG_DOUBLE_WINDOW, w);
    write_timing_reg(CFG_LONG_TIME, l);
    write_timing_reg(CFG_ROTATE_TIME, r);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_gesture();
    logic [StampW-1:0] start;
    logic [StampW-1:0] next;
    int n;
    start = clock_ms + 16'($urandom_range(1, 4000));
    case ($urandom_range(0, 9))
      0, 1: begin
        send_item(CMD_PRESS, start);
        send_item(CMD_RELEASE, start + near_threshold(dbl_window));
        n = $urandom_range(1, 3);
        repeat (n) send_item(CMD_TICK, start + near_threshold(dbl_window));
      end
      2, 3: begin
        send_item(CMD_PRESS, start);
        send_item(CMD_RELEASE, start + 16'($urandom_range(0, 60)));
        next = start + near_threshold(dbl_window);
        send_item(CMD_PRESS, next);
        send_item(CMD_RELEASE, next + 16'($urandom_range(0, 60)));
        send_item(CMD_TICK, next + near_threshold(dbl_window));
      end
      4: begin
        send_item(CMD_PRESS, start);
        n = $urandom_range(0, 3);
        repeat (n) send_item(CMD_TICK, start + near_threshold(long_time));
        send_item(CMD_RELEASE, start + near_threshold(long_time));
      end
      5: begin
        send_item(CMD_PRESS, start);
        if ($urandom_range(0, 2) != 0)
          send_item(CMD_RELEASE, start + 16'($urandom_range(0, 60)));
        send_item(CMD_ROTATE, start + near_threshold(rot_time));
        if ($urandom_range(0, 1) != 0)
          send_item(CMD_RELEASE, start + near_threshold(long_time));
      end
      6: begin
        // spaced press train: tally can climb to saturation
        next = start;
        n = $urandom_range(3, 5);
        repeat (n) begin
          send_item(CMD_PRESS, next);
          send_item(CMD_RELEASE, next + 16'($urandom_range(0, 60)));
          next = next + near_threshold(dbl_window);
        end
        send_item($urandom_range(0, 1) ? CMD_TICK : CMD_ROTATE, next);
      end
      7, 8: begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(cmd_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(CMD_TICK, start + near_threshold(dbl_window));
      end
    endcase
  endtask

  task automatic test_random_gestures(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) run_gesture();
  endtask

  task automatic test_directed_cases();
    // release and tick with nothing pending
    send_item(CMD_RELEASE, 16'd0);
    send_item(CMD_TICK, 16'hFFFF);
    // full-range hold
    send_item(CMD_PRESS, 16'd0);
    send_item(CMD_RELEASE, 16'hFFFF);
    // bounce is ignored; release right at the window keeps the press pending
    send_item(CMD_PRESS, 16'd100);
    send_item(CMD_PRESS, 16'd150);
    send_item(CMD_RELEASE, 16'd400);
    send_item(CMD_TICK, 16'd401);
    // second press exactly at the window
    send_item(CMD_PRESS, 16'd1000);
    send_item(CMD_RELEASE, 16'd1050);
    send_item(CMD_PRESS, 16'd1300);
    send_item(CMD_RELEASE, 16'd1320);
    // presses too far apart: tally saturates and stays inert until rotation
    send_item(CMD_PRESS, 16'd2000);
    send_item(CMD_RELEASE, 16'd2010);
    send_item(CMD_PRESS, 16'd2301);
    send_item(CMD_RELEASE, 16'd2320);
    send_item(CMD_PRESS, 16'd2700);
    send_item(CMD_RELEASE, 16'd2710);
    send_item(CMD_TICK, 16'd3900);
    send_item(CMD_ROTATE, 16'd3901);
    // long press caught by a tick while held
    send_item(CMD_PRESS, 16'd4000);
    send_item(CMD_TICK, 16'd5001);
    send_item(CMD_RELEASE, 16'd5002);
    // rotation switch with a pending single press
    send_item(CMD_PRESS, 16'd6000);
    send_item(CMD_RELEASE, 16'd6010);
    send_item(CMD_ROTATE, 16'd6501);
  endtask

  task automatic test_timing_extremes();
    set_timing(16'd0, 16'd0, 16'd0);
    test_random_gestures(150);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_gestures(150);
    set_timing(16'd800, 16'd200, 16'hFFFF);
    test_random_gestures(120);
  endtask

  task automatic test_random_timing();
    repeat (2) begin
      set_timing(16'($urandom_range(0, 600)), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(0, 1000)));
      test_random_gestures(200);
    end
  endtask

  // long output hold while items keep coming, then a full pause
  task automatic test_output_hold();
    drain_results();
    -> hold_start;
    test_random_gestures(80);
    drain_results();
  endtask

  task automatic test_unused_register();
    drain_results();
    write_timing_reg(CFG_UNUSED, 16'hFFFF);
    write_timing_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    test_random_gestures(60);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_gestures(250);
    test_timing_extremes();
    test_output_hold();
    test_random_timing();
    test_unused_register();
    set_timing(DOUBLE_WINDOW_RST, LONG_TIME_RST, ROTATE_TIME_RST);
    test_random_gestures(100);
    drain_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // output stall pattern: random duty, redrawn whenever its pattern counter runs out
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      pattern_left <= $urandom_range(32, 400);
      case ($urandom_range(0, 4))
        0, 1: stall_pct <= 0;
        2: stall_pct <= 20;
        3: stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
    end else begin
      pattern_left <= pattern_left - 1;
    end
    out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  always begin
    @(hold_start);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    gesture_t want;
    if (!rst && out_valid && !out_stall) begin
      if (gesture_q.size() == 0) begin
        report_mismatch($sformatf("unexpected gesture transfer %0d", gesture));
      end else begin
        want = gesture_q.pop_front();
        if (gesture !== want)
          report_mismatch($sformatf("gesture %0d, expected %s", gesture, want.name()));
      end
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sim.f
src/bgc_pkg.sv
src/button_gesture_classifier.sv
test/tb_top.sv
